@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ design/mncc_pkg.sv @@
// ----------------------------------------------------------------------------
// mncc_pkg
// types, codes and lookup tables of the midi note / cc command parser
// ----------------------------------------------------------------------------
package mncc_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CODE_W  = 3;
    localparam int unsigned VALUE_W = 19;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned CTRL_W  = 7;
    localparam int unsigned VOL_W   = 16;
    localparam int unsigned PHASE_LEN = 120;

    // configuration register indexes
    localparam logic [1:0] CFG_LISTEN_CHANNEL    = 2'd0;
    localparam logic [1:0] CFG_VOLUME_CONTROLLER = 2'd1;
    localparam logic [1:0] CFG_DEPTH_CONTROLLER  = 2'd2;
    localparam logic [1:0] CFG_RATIO_CONTROLLER  = 2'd3;

    // status byte high nibbles
    localparam logic [3:0] KIND_OFF = 4'h8;
    localparam logic [3:0] KIND_ON  = 4'h9;
    localparam logic [3:0] KIND_CC  = 4'hB;

    localparam logic [BYTE_W-1:0] REALTIME_FIRST = 8'hF8;

    // command codes
    localparam logic [CODE_W-1:0] CMD_NOTE_OFF = 3'd0;
    localparam logic [CODE_W-1:0] CMD_NOTE_ON  = 3'd1;
    localparam logic [CODE_W-1:0] CMD_DEPTH    = 3'd2;
    localparam logic [CODE_W-1:0] CMD_RATIO    = 3'd3;
    localparam logic [CODE_W-1:0] CMD_VOLUME   = 3'd7;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2
    } t_phase;

    typedef logic [VALUE_W-1:0] t_value;

    localparam logic [VALUE_W-1:0] PHASE_ROM [0:PHASE_LEN-1] = '{
        19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0, 19'd0,
        19'd0, 19'd0,
        19'd709, 19'd752, 19'd796, 19'd844, 19'd894, 19'd947, 19'd1003, 19'd1063,
        19'd1126, 19'd1193, 19'd1264, 19'd1339, 19'd1419, 19'd1503, 19'd1593,
        19'd1687, 19'd1788, 19'd1894, 19'd2006, 19'd2126, 19'd2252, 19'd2386,
        19'd2528, 19'd2678, 19'd2838, 19'd3006, 19'd3185, 19'd3374, 19'd3575,
        19'd3788, 19'd4013, 19'd4252, 19'd4504, 19'd4772, 19'd5056, 19'd5357,
        19'd5675, 19'd6013, 19'd6370, 19'd6749, 19'd7150, 19'd7575, 19'd8026,
        19'd8503, 19'd9009, 19'd9544, 19'd10112, 19'd10713, 19'd11350, 19'd12025,
        19'd12740, 19'd13498, 19'd14300, 19'd15151, 19'd16052, 19'd17006,
        19'd18017, 19'd19089, 19'd20224, 19'd21426, 19'd22700, 19'd24050,
        19'd25480, 19'd26996, 19'd28601, 19'd30301, 19'd32103, 19'd34012,
        19'd36035, 19'd38177, 19'd40448, 19'd42853, 19'd45401, 19'd48101,
        19'd50961, 19'd53991, 19'd57202, 19'd60603, 19'd64207, 19'd68025,
        19'd72070, 19'd76355, 19'd80895, 19'd85706, 19'd90802, 19'd96201,
        19'd101922, 19'd107982, 19'd114403, 19'd121206, 19'd128413, 19'd136049,
        19'd144139, 19'd152710, 19'd161791, 19'd171411, 19'd181604, 19'd192402,
        19'd203843, 19'd215964, 19'd228806, 19'd242412, 19'd256827, 19'd272098,
        19'd288278, 19'd305420, 19'd323581, 19'd342822
    };

    localparam logic [VOL_W-1:0] VOLUME_ROM [0:127] = '{
        16'd0, 16'd69, 16'd73, 16'd77, 16'd81, 16'd86, 16'd91, 16'd96, 16'd101,
        16'd107, 16'd113, 16'd119, 16'd126, 16'd133, 16'd140, 16'd148, 16'd156,
        16'd165, 16'd174, 16'd184, 16'd194, 16'd205, 16'd217, 16'd229, 16'd242,
        16'd255, 16'd270, 16'd285, 16'd301, 16'd317, 16'd335, 16'd354, 16'd374,
        16'd394, 16'd417, 16'd440, 16'd464, 16'd490, 16'd518, 16'd547, 16'd577,
        16'd610, 16'd644, 16'd680, 16'd718, 16'd758, 16'd800, 16'd845, 16'd892,
        16'd942, 16'd994, 16'd1050, 16'd1109, 16'd1171, 16'd1236, 16'd1305,
        16'd1378, 16'd1455, 16'd1537, 16'd1622, 16'd1713, 16'd1809, 16'd1910,
        16'd2017, 16'd2130, 16'd2249, 16'd2374, 16'd2507, 16'd2647, 16'd2795,
        16'd2951, 16'd3116, 16'd3290, 16'd3474, 16'd3669, 16'd3874, 16'd4090,
        16'd4319, 16'd4560, 16'd4815, 16'd5084, 16'd5369, 16'd5669, 16'd5986,
        16'd6320, 16'd6673, 16'd7046, 16'd7440, 16'd7856, 16'd8295, 16'd8759,
        16'd9249, 16'd9766, 16'd10312, 16'd10888, 16'd11497, 16'd12139, 16'd12818,
        16'd13534, 16'd14291, 16'd15090, 16'd15933, 16'd16824, 16'd17764,
        16'd18757, 16'd19806, 16'd20913, 16'd22082, 16'd23316, 16'd24619,
        16'd25996, 16'd27449, 16'd28983, 16'd30603, 16'd32314, 16'd34120,
        16'd36027, 16'd38041, 16'd40168, 16'd42413, 16'd44784, 16'd47287,
        16'd49930, 16'd52721, 16'd55668, 16'd58780, 16'd62066, 16'd65535
    };

    // notes above the table saturate at the top entry
    function automatic t_value note_phase(input logic [6:0] note);
        logic [6:0] idx;
        idx = (note >= 7'(PHASE_LEN)) ? 7'(PHASE_LEN - 1) : note;
        return PHASE_ROM[idx];
    endfunction

endpackage

@@ design/mncc_byte_if.sv @@
// ----------------------------------------------------------------------------
// mncc_byte_if
// valid / ready channel carrying one received midi byte
// ----------------------------------------------------------------------------
interface mncc_byte_if;
    logic                         valid;
    logic                         ready;
    logic [mncc_pkg::BYTE_W-1:0]  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/mncc_cmd_if.sv @@
// ----------------------------------------------------------------------------
// mncc_cmd_if
// valid / ready channel carrying one synthesizer command
// ----------------------------------------------------------------------------
interface mncc_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [mncc_pkg::CODE_W-1:0]   cmd_code;
    logic [mncc_pkg::VALUE_W-1:0]  cmd_value;

    modport source (output valid, output cmd_code, output cmd_value, input ready);
    modport sink   (input valid, input cmd_code, input cmd_value, output ready);
endinterface

@@ design/midi_note_cc_to_synth_command_top.sv @@
// ----------------------------------------------------------------------------
// midi_note_cc_to_synth_command_top
// midi channel message parser that turns note and cc bytes into commands
// ----------------------------------------------------------------------------
// usage:
//   i_in carries midi bytes, one per transaction; o_out carries commands
//   (cmd_code, cmd_value), at most one per byte. real-time bytes are dropped.
//   the config port writes listen channel and the three controller numbers;
//   write it only while no bytes are in flight.
// path: a byte is taken into an input register at its transaction, parsed
//   from that register, and its command is loaded into the output register
//   when the byte leaves it; o_out.valid is driven by the output register.
// throughput: one byte per cycle unless stalled; the parse state and both
//   table lookups are evaluated in a single pass from the input register.
// stall: while o_out is held off, the output register keeps its command and
//   one more byte is still taken into the input register; bytes that make
//   no command keep flowing through.
// reset: synchronous, active low; the parser goes idle, both stages empty,
//   config returns to channel 0, volume cc 7, depth cc 1, ratio cc 2.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_note_cc_to_synth_command_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [mncc_pkg::CTRL_W-1:0]   i_cfg_data,
    mncc_byte_if.sink                     i_in,
    mncc_cmd_if.source                    o_out
);

    // configuration
    logic [mncc_pkg::CHAN_W-1:0] r_listen_channel;
    logic [mncc_pkg::CTRL_W-1:0] r_volume_ctrl;
    logic [mncc_pkg::CTRL_W-1:0] r_depth_ctrl;
    logic [mncc_pkg::CTRL_W-1:0] r_ratio_ctrl;

    // input stage
    logic                        r_in_valid;
    logic [mncc_pkg::BYTE_W-1:0] r_in_byte;

    // parse state
    mncc_pkg::t_phase            r_phase, n_phase;
    logic [3:0]                  r_kind, n_kind;
    logic [6:0]                  r_first, n_first;

    // output stage
    logic                        r_out_valid;
    logic [mncc_pkg::CODE_W-1:0] r_out_code;
    mncc_pkg::t_value            r_out_value;

    // parse results
    logic                        emit;
    logic [mncc_pkg::CODE_W-1:0] emit_code;
    mncc_pkg::t_value            emit_value;
    logic                        advance;

    logic                        is_realtime;
    logic                        is_status;
    logic [6:0]                  data_bits;
    logic [7:0]                  ratio_sum;

    assign is_realtime = (r_in_byte >= mncc_pkg::REALTIME_FIRST);
    assign is_status   = r_in_byte[7];
    assign data_bits   = r_in_byte[6:0];
    assign ratio_sum   = {1'b0, data_bits} + 8'd16;

    // a byte leaves the input register unless its command would overwrite one
    assign advance = r_in_valid && (!emit || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_listen_channel <= '0;
            r_volume_ctrl    <= 7'd7;
            r_depth_ctrl     <= 7'd1;
            r_ratio_ctrl     <= 7'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mncc_pkg::CFG_LISTEN_CHANNEL:    r_listen_channel <= i_cfg_data[3:0];
                mncc_pkg::CFG_VOLUME_CONTROLLER: r_volume_ctrl    <= i_cfg_data;
                mncc_pkg::CFG_DEPTH_CONTROLLER:  r_depth_ctrl     <= i_cfg_data;
                mncc_pkg::CFG_RATIO_CONTROLLER:  r_ratio_ctrl     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte <= i_in.rx_byte;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_first = r_first;
        if (is_realtime) begin
            n_phase = r_phase;
        end else if (is_status) begin
            n_kind = r_in_byte[7:4];
            if ((r_in_byte[3:0] == r_listen_channel) &&
                (r_in_byte[7:4] inside {mncc_pkg::KIND_OFF, mncc_pkg::KIND_ON,
                                        mncc_pkg::KIND_CC})) begin
                n_phase = mncc_pkg::PH_FIRST;
            end else begin
                n_phase = mncc_pkg::PH_IDLE;
            end
        end else begin
            case (r_phase)
                mncc_pkg::PH_FIRST: begin
                    n_first = data_bits;
                    n_phase = mncc_pkg::PH_SECOND;
                end
                mncc_pkg::PH_SECOND: n_phase = mncc_pkg::PH_SECOND;
                default:             n_phase = mncc_pkg::PH_IDLE;
            endcase
        end
    end

    // command generation
    always_comb begin
        emit       = 1'b0;
        emit_code  = mncc_pkg::CMD_NOTE_OFF;
        emit_value = '0;
        if (!is_status) begin
            case (r_phase)
                mncc_pkg::PH_FIRST: begin
                    if (r_kind == mncc_pkg::KIND_OFF) begin
                        emit      = 1'b1;
                        emit_code = mncc_pkg::CMD_NOTE_OFF;
                    end else if (r_kind == mncc_pkg::KIND_ON) begin
                        emit       = 1'b1;
                        emit_code  = mncc_pkg::CMD_NOTE_ON;
                        emit_value = mncc_pkg::note_phase(data_bits);
                    end
                end
                mncc_pkg::PH_SECOND: begin
                    // later matches override earlier ones
                    if (r_kind == mncc_pkg::KIND_CC) begin
                        if (r_first == r_volume_ctrl) begin
                            emit       = 1'b1;
                            emit_code  = mncc_pkg::CMD_VOLUME;
                            emit_value = mncc_pkg::VALUE_W'(mncc_pkg::VOLUME_ROM[data_bits]);
                        end
                        if (r_first == r_depth_ctrl) begin
                            emit       = 1'b1;
                            emit_code  = mncc_pkg::CMD_DEPTH;
                            emit_value = mncc_pkg::VALUE_W'(data_bits);
                        end
                        if (r_first == r_ratio_ctrl) begin
                            emit       = 1'b1;
                            emit_code  = mncc_pkg::CMD_RATIO;
                            emit_value = mncc_pkg::VALUE_W'(ratio_sum[7:5]);
                        end
                    end
                end
                default: emit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mncc_pkg::PH_IDLE;
            r_kind  <= '0;
            r_first <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_code  <= emit_code;
            r_out_value <= emit_value;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.cmd_code  = r_out_code;
    assign o_out.cmd_value = r_out_value;

    `ASSERT_NEXT(a_emit_loads_out, i_clk, i_rst_n, advance && emit, r_out_valid,
        "command lost on its way to the output register")
    `ASSERT_NEXT(a_blocked_byte_held, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in_byte), "blocked byte left the input register")
    `ASSERT_ALWAYS(a_note_off_zero, i_clk, i_rst_n,
        !(r_out_valid && r_out_code == mncc_pkg::CMD_NOTE_OFF) || r_out_value == '0,
        "note off command with nonzero value")
    `ASSERT_NEXT(a_foreign_status_idles, i_clk, i_rst_n,
        advance && is_status && !is_realtime && r_in_byte[3:0] != r_listen_channel,
        r_phase == mncc_pkg::PH_IDLE, "status of another channel did not idle the parser")

endmodule
